FILE: rtl/preemptive_hrrn_scheduler_unit_defines.svh
// Assertion macros used by the scheduler top level.
`ifndef PREEMPTIVE_HRRN_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_HRRN_SCHEDULER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PHRS_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Condition that must hold in the same cycle as its trigger.
`define PHRS_ASSERT_IMPLY(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define PHRS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/phrs_pkg.sv
// Shared constants, types and codes of the preemptive HRRN scheduler.
package phrs_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [15:0] CLOCK_START = 16'd1;
    localparam logic [15:0] CLOCK_TOP   = 16'hFFFF;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Response status codes
    localparam logic [2:0] RSP_IDLE   = 3'd0;
    localparam logic [2:0] RSP_RAN    = 3'd1;
    localparam logic [2:0] RSP_DONE   = 3'd2;
    localparam logic [2:0] RSP_LOADED = 3'd3;
    localparam logic [2:0] RSP_FULL   = 3'd4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] remaining;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Control from the sequencer to the selection datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic update;
        idx_t idx;
    } sel_ctrl_t;

    // Current winner of the scan
    typedef struct packed {
        logic   found;
        idx_t   best_idx;
        entry_t best;
    } sel_stat_t;

endpackage

FILE: rtl/phrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module phrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold data while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/phrs_select.sv
// Response-ratio comparison datapath that tracks the best task of a scan.
module phrs_select (
    input  logic                clk,
    input  logic                rst_n,
    input  phrs_pkg::sel_ctrl_t ctrl,
    input  phrs_pkg::entry_t    entry,
    input  logic [15:0]         clock,
    output phrs_pkg::sel_stat_t stat
);
    import phrs_pkg::*;

    entry_t      cand_reg;
    idx_t        cand_idx_reg;
    logic        cand_arrived_reg;
    logic [16:0] cand_num_reg;
    logic [32:0] prod_cand_reg;
    logic [32:0] prod_best_reg;

    entry_t      best_reg;
    idx_t        best_idx_reg;
    logic [16:0] best_num_reg;
    logic        found_reg;

    logic [16:0] cand_num;
    logic        wins;

    // Numerator of the ratio: waiting time plus remaining service
    assign cand_num = {1'b0, clock - entry.arrival} + {1'b0, entry.remaining};

    // Capture candidate and cross-multiply against the current best
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cand_reg         <= entry;
            cand_idx_reg     <= ctrl.idx;
            cand_arrived_reg <= (entry.arrival < clock);
            cand_num_reg     <= cand_num;
            prod_cand_reg    <= 33'(cand_num) * 33'(best_reg.remaining);
            prod_best_reg    <= 33'(best_num_reg) * 33'(entry.remaining);
        end
    end

    // Higher ratio wins; on equal ratio the earlier arrival wins, else keep the earlier slot
    always_comb
    begin
        wins = 1'b0;
        if (cand_arrived_reg)
        begin
            if (!found_reg)
            begin
                wins = 1'b1;
            end
            else if (prod_cand_reg > prod_best_reg)
            begin
                wins = 1'b1;
            end
            else if (prod_cand_reg == prod_best_reg && cand_reg.arrival < best_reg.arrival)
            begin
                wins = 1'b1;
            end
        end
    end

    // Found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.update && wins)
        begin
            found_reg <= 1'b1;
        end
    end

    // Best candidate payload
    always_ff @(posedge clk)
    begin
        if (ctrl.update && wins)
        begin
            best_reg     <= cand_reg;
            best_idx_reg <= cand_idx_reg;
            best_num_reg <= cand_num_reg;
        end
    end

    assign stat.found    = found_reg;
    assign stat.best_idx = best_idx_reg;
    assign stat.best     = best_reg;

endmodule

FILE: rtl/preemptive_hrrn_scheduler_unit.sv
// Top level of the preemptive HRRN scheduler: sequencer, task table RAM, response path.
//
//   channel  | handshake           | payload
//   request  | req_valid/req_stall | req_type, task_id, arrival_time, burst_length
//   response | rsp_valid/rsp_stall | status, chosen_id, clock_value, left_after
//
// A load, or a tick on an empty table, goes from DECODE to PUT, which writes the output
// register. A tick scans the N tasks in the table with EVAL and CMP per entry (RAM read
// and multiply, then compare, as the one table RAM reads one slot at a time), then
// DECIDE, then SHIFT once per later entry moved down when the chosen task finishes,
// then PUT. The next request is accepted once the sequencer is back in IDLE.
// Reset clears the fill count, sets the tick clock to one; no clearing pass runs.
// A stalled response holds in the output register while the next request is worked.
`include "preemptive_hrrn_scheduler_unit_defines.svh"

module preemptive_hrrn_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [7:0]  task_id,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_length,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [7:0]  chosen_id,
    output logic [15:0] clock_value,
    output logic [15:0] left_after
);
    import phrs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_SHIFT  = 3'd5;
    localparam logic [2:0] S_PUT    = 3'd6;

    logic [2:0]  state_reg, state_next;
    cnt_t        count_reg, count_next;
    logic [15:0] clock_reg, clock_next;
    idx_t        idx_reg, idx_next;
    idx_t        ptr_reg, ptr_next;

    logic        req_type_reg;
    logic [7:0]  req_id_reg;
    logic [15:0] req_arrival_reg;
    logic [15:0] req_burst_reg;

    logic        res_load;
    logic [2:0]  res_status_reg, res_status_next;
    logic [7:0]  res_id_reg, res_id_next;
    logic [15:0] res_left_reg, res_left_next;

    logic        out_load;
    logic        rsp_valid_reg;
    logic [2:0]  status_reg;
    logic [7:0]  chosen_id_reg;
    logic [15:0] clock_value_reg;
    logic [15:0] left_after_reg;

    logic        ram_wr_en;
    idx_t        ram_wr_addr;
    entry_t      ram_wr_data;
    logic        ram_rd_en;
    idx_t        ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_raw;
    entry_t      ram_rd_data;

    sel_ctrl_t   sel_ctrl;
    sel_stat_t   sel_stat;

    logic        accept;
    logic        full;
    idx_t        last_idx;
    logic [15:0] left_val;
    logic [15:0] load_burst;

    assign req_stall   = (state_reg != S_IDLE);
    assign accept      = req_valid && !req_stall;
    assign full        = (count_reg == cnt_t'(MAX_TASKS));
    assign last_idx    = idx_t'(count_reg - cnt_t'(1));
    assign left_val    = sel_stat.best.remaining - 16'd1;
    assign load_burst  = (req_burst_reg == 16'd0) ? 16'd1 : req_burst_reg;
    assign ram_rd_data = entry_t'(ram_rd_raw);

    // Task table
    phrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    // Ratio comparison
    phrs_select u_select (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sel_ctrl),
        .entry (ram_rd_data),
        .clock (clock_reg),
        .stat  (sel_stat)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        clock_next      = clock_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_t'(0);
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx_t'(0);
        sel_ctrl        = '0;
        res_load        = 1'b0;
        res_status_next = RSP_IDLE;
        res_id_next     = 8'd0;
        res_left_next   = 16'd0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (req_type_reg == REQ_LOAD)
                begin
                    res_load    = 1'b1;
                    res_id_next = req_id_reg;
                    if (full)
                    begin
                        res_status_next = RSP_FULL;
                    end
                    else
                    begin
                        // Append the task at the end of the packed table
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = idx_t'(count_reg);
                        ram_wr_data.id        = req_id_reg;
                        ram_wr_data.arrival   = req_arrival_reg;
                        ram_wr_data.remaining = load_burst;
                        count_next        = count_reg + cnt_t'(1);
                        res_status_next   = RSP_LOADED;
                        res_left_next     = load_burst;
                    end
                    state_next = S_PUT;
                end
                else if (count_reg == cnt_t'(0))
                begin
                    res_load        = 1'b1;
                    res_status_next = RSP_IDLE;
                    state_next      = S_PUT;
                end
                else
                begin
                    // Start the scan at slot zero
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = idx_t'(0);
                    sel_ctrl.clear = 1'b1;
                    idx_next       = idx_t'(0);
                    state_next     = S_EVAL;
                end
            end
            S_EVAL:
            begin
                sel_ctrl.capture = 1'b1;
                sel_ctrl.idx     = idx_reg;
                if (idx_reg != last_idx)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_t'(idx_reg + 1'b1);
                end
                state_next = S_CMP;
            end
            S_CMP:
            begin
                sel_ctrl.update = 1'b1;
                if (idx_reg == last_idx)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_t'(idx_reg + 1'b1);
                    state_next = S_EVAL;
                end
            end
            S_DECIDE:
            begin
                res_load = 1'b1;
                if (!sel_stat.found)
                begin
                    res_status_next = RSP_IDLE;
                    state_next      = S_PUT;
                end
                else
                begin
                    res_id_next   = sel_stat.best.id;
                    res_left_next = left_val;
                    if (left_val != 16'd0)
                    begin
                        // Write back the reduced remaining time
                        res_status_next       = RSP_RAN;
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = sel_stat.best_idx;
                        ram_wr_data           = sel_stat.best;
                        ram_wr_data.remaining = left_val;
                        state_next            = S_PUT;
                    end
                    else
                    begin
                        res_status_next = RSP_DONE;
                        if (sel_stat.best_idx == last_idx)
                        begin
                            count_next = count_reg - cnt_t'(1);
                            state_next = S_PUT;
                        end
                        else
                        begin
                            // Move later entries down one slot
                            ptr_next    = sel_stat.best_idx;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = idx_t'(sel_stat.best_idx + 1'b1);
                            state_next  = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg;
                ram_wr_data = ram_rd_data;
                if (idx_t'(ptr_reg + 1'b1) == last_idx)
                begin
                    count_next = count_reg - cnt_t'(1);
                    state_next = S_PUT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_t'(ptr_reg + 2'd2);
                    ptr_next    = idx_t'(ptr_reg + 1'b1);
                end
            end
            S_PUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    // Advance the tick clock, saturate at the top
                    if (req_type_reg == REQ_TICK && clock_reg != CLOCK_TOP)
                    begin
                        clock_next = clock_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= cnt_t'(0);
            clock_reg     <= CLOCK_START;
            idx_reg       <= idx_t'(0);
            ptr_reg       <= idx_t'(0);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clock_reg <= clock_next;
            idx_reg   <= idx_next;
            ptr_reg   <= ptr_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg    <= req_type;
            req_id_reg      <= task_id;
            req_arrival_reg <= arrival_time;
            req_burst_reg   <= burst_length;
        end
    end

    // Result staging
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_left_reg   <= res_left_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg      <= res_status_reg;
            chosen_id_reg   <= res_id_reg;
            clock_value_reg <= clock_reg;
            left_after_reg  <= res_left_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign chosen_id   = chosen_id_reg;
    assign clock_value = clock_value_reg;
    assign left_after  = left_after_reg;

    `PHRS_ASSERT_ALWAYS(a_count_range, count_reg <= cnt_t'(MAX_TASKS), "task count above table size")
    `PHRS_ASSERT_ALWAYS(a_clock_nonzero, clock_reg != 16'd0, "tick clock wrapped to zero")
    `PHRS_ASSERT_IMPLY(a_shift_in_table, state_reg == S_SHIFT, ptr_reg < last_idx, "shift past end")
    `PHRS_ASSERT_IMPLY(a_best_in_table, state_reg == S_DECIDE && sel_stat.found, cnt_t'(sel_stat.best_idx) < count_reg, "chosen slot beyond table")
    `PHRS_ASSERT_NEXT(a_put_clears_busy, out_load, state_reg == S_IDLE, "response load without return to idle")

endmodule
